/* sv/sgaw_pkg.sv */
// ----------------------------------------------------------------------------
// sgaw_pkg: shared types and constants for the strided get address walker
// payload structs, register map and configuration defaults
// ----------------------------------------------------------------------------
package sgaw_pkg;

    localparam int MAX_LEVELS_DEF  = 2;
    localparam int ADDR_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_LEVELS_IN_USE    = 3'd0,
        REG_BLOCK_LENGTH     = 3'd1,
        REG_COUNT_INNER      = 3'd2,
        REG_COUNT_OUTER      = 3'd3,
        REG_SRC_STRIDE_INNER = 3'd4,
        REG_SRC_STRIDE_OUTER = 3'd5,
        REG_DST_STRIDE_INNER = 3'd6,
        REG_DST_STRIDE_OUTER = 3'd7
    } reg_index_t;

    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [15:0] peer_rank;
        logic [31:0] src_start;
        logic [31:0] dst_start;
    } in_item_t;

    typedef struct packed {
        logic [15:0] peer_out;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] chunk_bytes;
        logic        last;
        logic        error;
    } out_item_t;

    typedef struct packed {
        logic [1:0]         levels_in_use;
        logic [15:0]        block_length;
        logic [15:0]        count_inner;
        logic [15:0]        count_outer;
        logic signed [31:0] src_stride_inner;
        logic signed [31:0] src_stride_outer;
        logic signed [31:0] dst_stride_inner;
        logic signed [31:0] dst_stride_outer;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        levels_in_use:    2'd0,
        block_length:     16'd1,
        count_inner:      16'd1,
        count_outer:      16'd1,
        src_stride_inner: 32'sd0,
        src_stride_outer: 32'sd0,
        dst_stride_inner: 32'sd0,
        dst_stride_outer: 32'sd0
    };

endpackage

/* sv/strided_get_address_walker.sv */
// ----------------------------------------------------------------------------
// strided_get_address_walker: two-level strided get command generator
// latency: a result is valid in the cycle after its input transaction
// throughput: one transaction per cycle while results are taken, bounded by one address add per side
// in_ready drops only while a finished result is held by out_ready low
// reset clears the walk state (no active transfer) and loads register defaults
// ----------------------------------------------------------------------------
module strided_get_address_walker #(
    parameter int MAX_LEVELS  = sgaw_pkg::MAX_LEVELS_DEF,
    parameter int ADDR_WIDTH  = sgaw_pkg::ADDR_WIDTH_DEF,
    parameter int COUNT_WIDTH = sgaw_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sgaw_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output sgaw_pkg::out_item_t                  out_data,
    input  logic                                 cfg_write,
    input  logic [sgaw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sgaw_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    sgaw_pkg::cfg_t cfg;

    sgaw_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // walk state
    logic [ADDR_WIDTH-1:0]  cur_src_reg, cur_src_next;
    logic [ADDR_WIDTH-1:0]  cur_dst_reg, cur_dst_next;
    logic [ADDR_WIDTH-1:0]  row_src_reg, row_src_next;
    logic [ADDR_WIDTH-1:0]  row_dst_reg, row_dst_next;
    logic [COUNT_WIDTH-1:0] inner_reg, inner_next;
    logic [COUNT_WIDTH-1:0] outer_reg, outer_next;
    logic [15:0]            peer_reg, peer_next;
    logic                   busy_reg, busy_next;

    logic                   out_valid_reg, out_valid_next;
    sgaw_pkg::out_item_t    out_data_reg, out_data_next;

    logic                   accept;
    logic                   is_start;
    logic                   is_error;
    logic                   lvl1_on;
    logic                   lvl2_on;
    logic [COUNT_WIDTH-1:0] cnt_in_raw, cnt_out_raw;
    logic [COUNT_WIDTH-1:0] cnt_in, cnt_out;
    logic [ADDR_WIDTH-1:0]  base_src, base_dst, base_row_src, base_row_dst;
    logic [COUNT_WIDTH-1:0] base_inner, base_outer;
    logic [15:0]            base_peer;
    logic                   inner_end, outer_end, is_last;
    logic [ADDR_WIDTH-1:0]  row_src_step, row_dst_step;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign is_start = (in_data.opcode == sgaw_pkg::OP_START);
    assign is_error = !is_start && !busy_reg;

    // levels above the maximum act as the maximum
    assign lvl1_on = (cfg.levels_in_use != 2'd0);
    assign lvl2_on = (MAX_LEVELS >= 2) && (cfg.levels_in_use >= 2'd2);

    assign cnt_in_raw  = COUNT_WIDTH'(cfg.count_inner);
    assign cnt_out_raw = COUNT_WIDTH'(cfg.count_outer);
    assign cnt_in  = (lvl1_on && cnt_in_raw != '0) ? cnt_in_raw : COUNT_WIDTH'(1);
    assign cnt_out = (lvl2_on && cnt_out_raw != '0) ? cnt_out_raw : COUNT_WIDTH'(1);

    // a start loads the walk origin in the same cycle it is issued
    assign base_src     = is_start ? ADDR_WIDTH'(in_data.src_start) : cur_src_reg;
    assign base_dst     = is_start ? ADDR_WIDTH'(in_data.dst_start) : cur_dst_reg;
    assign base_row_src = is_start ? ADDR_WIDTH'(in_data.src_start) : row_src_reg;
    assign base_row_dst = is_start ? ADDR_WIDTH'(in_data.dst_start) : row_dst_reg;
    assign base_inner   = is_start ? '0 : inner_reg;
    assign base_outer   = is_start ? '0 : outer_reg;
    assign base_peer    = is_start ? in_data.peer_rank : peer_reg;

    // index + 1 >= count, with count at least one
    assign inner_end = (base_inner >= cnt_in - COUNT_WIDTH'(1));
    assign outer_end = (base_outer >= cnt_out - COUNT_WIDTH'(1));
    assign is_last   = inner_end && outer_end;

    assign row_src_step = base_row_src + ADDR_WIDTH'(cfg.src_stride_outer);
    assign row_dst_step = base_row_dst + ADDR_WIDTH'(cfg.dst_stride_outer);

    always_comb
    begin
        cur_src_next = cur_src_reg;
        cur_dst_next = cur_dst_reg;
        row_src_next = row_src_reg;
        row_dst_next = row_dst_reg;
        inner_next   = inner_reg;
        outer_next   = outer_reg;
        peer_next    = peer_reg;
        busy_next    = busy_reg;
        if (accept && !is_error)
        begin
            cur_src_next = base_src;
            cur_dst_next = base_dst;
            row_src_next = base_row_src;
            row_dst_next = base_row_dst;
            inner_next   = base_inner;
            outer_next   = base_outer;
            peer_next    = base_peer;
            busy_next    = !is_last;
            if (!is_last)
            begin
                if (!inner_end)
                begin
                    inner_next   = base_inner + COUNT_WIDTH'(1);
                    cur_src_next = base_src + ADDR_WIDTH'(cfg.src_stride_inner);
                    cur_dst_next = base_dst + ADDR_WIDTH'(cfg.dst_stride_inner);
                end
                else
                begin
                    // row wrap: back to the row start, then one outer step
                    inner_next   = '0;
                    outer_next   = base_outer + COUNT_WIDTH'(1);
                    row_src_next = row_src_step;
                    row_dst_next = row_dst_step;
                    cur_src_next = row_src_step;
                    cur_dst_next = row_dst_step;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (is_error)
            begin
                out_data_next       = '0;
                out_data_next.error = 1'b1;
            end
            else
            begin
                out_data_next.peer_out    = base_peer;
                out_data_next.src_addr    = 32'(base_src);
                out_data_next.dst_addr    = 32'(base_dst);
                out_data_next.chunk_bytes = cfg.block_length;
                out_data_next.last        = is_last;
                out_data_next.error       = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_src_reg   <= '0;
            cur_dst_reg   <= '0;
            row_src_reg   <= '0;
            row_dst_reg   <= '0;
            inner_reg     <= '0;
            outer_reg     <= '0;
            peer_reg      <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_src_reg   <= cur_src_next;
            cur_dst_reg   <= cur_dst_next;
            row_src_reg   <= row_src_next;
            row_dst_reg   <= row_dst_next;
            inner_reg     <= inner_next;
            outer_reg     <= outer_next;
            peer_reg      <= peer_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* sv/sgaw_regs.sv */
// ----------------------------------------------------------------------------
// sgaw_regs: configuration register file
// decodes the write port into the transfer shape registers
// ----------------------------------------------------------------------------
module sgaw_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [sgaw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [sgaw_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output sgaw_pkg::cfg_t                       cfg
);

    sgaw_pkg::cfg_t cfg_reg;
    sgaw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (sgaw_pkg::reg_index_t'(cfg_index))
                sgaw_pkg::REG_LEVELS_IN_USE:    cfg_next.levels_in_use    = cfg_data[1:0];
                sgaw_pkg::REG_BLOCK_LENGTH:     cfg_next.block_length     = cfg_data[15:0];
                sgaw_pkg::REG_COUNT_INNER:      cfg_next.count_inner      = cfg_data[15:0];
                sgaw_pkg::REG_COUNT_OUTER:      cfg_next.count_outer      = cfg_data[15:0];
                sgaw_pkg::REG_SRC_STRIDE_INNER: cfg_next.src_stride_inner = cfg_data[31:0];
                sgaw_pkg::REG_SRC_STRIDE_OUTER: cfg_next.src_stride_outer = cfg_data[31:0];
                sgaw_pkg::REG_DST_STRIDE_INNER: cfg_next.dst_stride_inner = cfg_data[31:0];
                sgaw_pkg::REG_DST_STRIDE_OUTER: cfg_next.dst_stride_outer = cfg_data[31:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= sgaw_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/sgaw_checker.sv */
// ----------------------------------------------------------------------------
// sgaw_checker: port-level checks for the strided get address walker
// watches the channels only and is bound to the top level
// ----------------------------------------------------------------------------
module sgaw_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input sgaw_pkg::out_item_t out_data
);

    // a stalled result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // every input transaction shows up as a result in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("input transaction produced no result");

    // input side stalls only while a result is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // an error result carries no command
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error |-> !out_data.last && out_data.src_addr == 32'd0
            && out_data.dst_addr == 32'd0 && out_data.peer_out == 16'd0
            && out_data.chunk_bytes == 16'd0)
        else $error("error result carries command fields");

endmodule

bind strided_get_address_walker sgaw_checker u_sgaw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* tb/sv/get_command_checker.sv */
// ----------------------------------------------------------------------------
// get_command_checker: watches the strided get walker and checks its commands
// keeps its own copy of the registers and walk state, works out the command
// for every accepted input transaction and compares it with the next output
// transaction, field by field
// ----------------------------------------------------------------------------
module get_command_checker
    import sgaw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_ready,
    input  in_item_t  in_data,
    input  logic      out_valid,
    input  logic      out_ready,
    input  out_item_t out_data,
    input  logic      cfg_write,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output int        failures,
    output int        outstanding
);

    cfg_t        regs;
    logic [31:0] cur_src;
    logic [31:0] cur_dst;
    logic [31:0] row_src;
    logic [31:0] row_dst;
    logic [15:0] inner_idx;
    logic [15:0] outer_idx;
    logic [15:0] peer_hold;
    logic        active;
    out_item_t   pending_cmds[$];
    out_item_t   oldest;

    initial failures = 0;

    // count along one stride level, as the walk sees it
    function automatic int span(logic [15:0] count, int level);
        int lv;
        lv = (regs.levels_in_use > MAX_LEVELS_DEF) ? MAX_LEVELS_DEF : regs.levels_in_use;
        if (lv < level || count == 16'd0)
            return 1;
        return count;
    endfunction

    function automatic out_item_t walk_chunk(in_item_t item);
        out_item_t cmd;
        int        n_inner;
        int        n_outer;
        logic      final_chunk;
        cmd = '0;
        if (item.opcode == OP_START)
        begin
            // a start drops whatever transfer was running
            peer_hold = item.peer_rank;
            cur_src   = item.src_start;
            cur_dst   = item.dst_start;
            row_src   = item.src_start;
            row_dst   = item.dst_start;
            inner_idx = '0;
            outer_idx = '0;
            active    = 1'b1;
        end
        else if (!active)
        begin
            cmd.error = 1'b1;
            return cmd;
        end
        n_inner = span(regs.count_inner, 1);
        n_outer = span(regs.count_outer, 2);
        final_chunk = (int'(inner_idx) + 1 >= n_inner) && (int'(outer_idx) + 1 >= n_outer);
        cmd.peer_out    = peer_hold;
        cmd.src_addr    = cur_src;
        cmd.dst_addr    = cur_dst;
        cmd.chunk_bytes = regs.block_length;
        cmd.last        = final_chunk;
        if (final_chunk)
            active = 1'b0;
        else if (int'(inner_idx) + 1 < n_inner)
        begin
            inner_idx = inner_idx + 16'd1;
            cur_src   = cur_src + regs.src_stride_inner;
            cur_dst   = cur_dst + regs.dst_stride_inner;
        end
        else
        begin
            // end of row: back to the row start, then one outer step
            inner_idx = '0;
            outer_idx = outer_idx + 16'd1;
            row_src   = row_src + regs.src_stride_outer;
            row_dst   = row_dst + regs.dst_stride_outer;
            cur_src   = row_src;
            cur_dst   = row_dst;
        end
        return cmd;
    endfunction

    task automatic flag(string what, out_item_t want, out_item_t got);
        failures++;
        if (failures <= 10)
            $display("%0t %s: expected peer=%h src=%h dst=%h bytes=%h last=%b err=%b",
                     $time, what, want.peer_out, want.src_addr, want.dst_addr,
                     want.chunk_bytes, want.last, want.error,
                     "\n    got peer=%h src=%h dst=%h bytes=%h last=%b err=%b",
                     got.peer_out, got.src_addr, got.dst_addr,
                     got.chunk_bytes, got.last, got.error);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs      = CFG_RESET;
            cur_src   = '0;
            cur_dst   = '0;
            row_src   = '0;
            row_dst   = '0;
            inner_idx = '0;
            outer_idx = '0;
            peer_hold = '0;
            active    = 1'b0;
            pending_cmds.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_cmds.size() == 0)
                    flag("unexpected command", '0, out_data);
                else
                begin
                    oldest = pending_cmds.pop_front();
                    if (out_data.peer_out !== oldest.peer_out ||
                        out_data.src_addr !== oldest.src_addr ||
                        out_data.dst_addr !== oldest.dst_addr ||
                        out_data.chunk_bytes !== oldest.chunk_bytes ||
                        out_data.last !== oldest.last ||
                        out_data.error !== oldest.error)
                        flag("command mismatch", oldest, out_data);
                end
            end
            if (in_valid && in_ready)
                pending_cmds.push_back(walk_chunk(in_data));
            // register writes count from the next transaction on
            if (cfg_write)
            begin
                case (reg_index_t'(cfg_index))
                    REG_LEVELS_IN_USE:    regs.levels_in_use    = cfg_data[1:0];
                    REG_BLOCK_LENGTH:     regs.block_length     = cfg_data[15:0];
                    REG_COUNT_INNER:      regs.count_inner      = cfg_data[15:0];
                    REG_COUNT_OUTER:      regs.count_outer      = cfg_data[15:0];
                    REG_SRC_STRIDE_INNER: regs.src_stride_inner = cfg_data;
                    REG_SRC_STRIDE_OUTER: regs.src_stride_outer = cfg_data;
                    REG_DST_STRIDE_INNER: regs.dst_stride_inner = cfg_data;
                    REG_DST_STRIDE_OUTER: regs.dst_stride_outer = cfg_data;
                    default: ;
                endcase
            end
            outstanding <= pending_cmds.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the strided get address walker
// a directed opening walks the corner cases, then random register settings
// carry mostly well-formed transfers mixed with stray and cut-short ones;
// sender bursts and receiver stalls vary throughout
// ----------------------------------------------------------------------------
module testbench;
    import sgaw_pkg::*;

    typedef enum int {RX_OPEN, RX_COIN, RX_TIGHT, RX_PERIODIC} rx_mode_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    in_item_t                   in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    out_item_t                  out_data;
    logic                       cfg_write = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;

    int       failures;
    int       outstanding;
    int       items_sent = 0;
    int       burst_left = 0;
    cfg_t     setting    = CFG_RESET;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       rx_tick    = 0;

    strided_get_address_walker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    get_command_checker cmd_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // receiver: stall style is redrawn whenever its random hold count runs out
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (rx_left == 0)
        begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= $urandom_range(20, 200);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            RX_OPEN:  out_ready <= 1'b1;
            RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
            RX_TIGHT: out_ready <= ($urandom_range(0, 4) == 0);
            default:  out_ready <= (rx_tick % 6) < 2;
        endcase
    end

    function automatic in_item_t make_item(logic op);
        in_item_t item;
        item.opcode    = op;
        item.peer_rank = 16'($urandom);
        item.src_start = $urandom;
        item.dst_start = $urandom;
        return item;
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 9))
            0, 1:    return 16'd0;
            2:       return 16'hffff;
            3, 4:    return 16'($urandom_range(7, 12));
            default: return 16'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [31:0] pick_stride();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hffff_ffff;
            3:       return 32'h7fff_ffff;
            4:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic cfg_t random_setting();
        cfg_t s;
        s.levels_in_use = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0:       s.block_length = 16'd0;
            1:       s.block_length = 16'hffff;
            default: s.block_length = 16'($urandom);
        endcase
        s.count_inner      = pick_count();
        s.count_outer      = pick_count();
        s.src_stride_inner = pick_stride();
        s.src_stride_outer = pick_stride();
        s.dst_stride_inner = pick_stride();
        s.dst_stride_outer = pick_stride();
        return s;
    endfunction

    // chunks in one full transfer under a setting
    function automatic longint chunks_of(cfg_t s);
        longint n_inner;
        longint n_outer;
        n_inner = (s.levels_in_use >= 1 && s.count_inner != 0) ? s.count_inner : 1;
        n_outer = (s.levels_in_use >= 2 && s.count_outer != 0) ? s.count_outer : 1;
        return n_inner * n_outer;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(cfg_t s);
        write_reg(REG_LEVELS_IN_USE, 32'(s.levels_in_use));
        write_reg(REG_BLOCK_LENGTH, 32'(s.block_length));
        write_reg(REG_COUNT_INNER, 32'(s.count_inner));
        write_reg(REG_COUNT_OUTER, 32'(s.count_outer));
        write_reg(REG_SRC_STRIDE_INNER, s.src_stride_inner);
        write_reg(REG_SRC_STRIDE_OUTER, s.src_stride_outer);
        write_reg(REG_DST_STRIDE_INNER, s.dst_stride_inner);
        write_reg(REG_DST_STRIDE_OUTER, s.dst_stride_outer);
        setting = s;
    endtask

    task automatic send_item(in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 24);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        burst_left--;
        items_sent++;
    endtask

    // hold off until every command asked for has come out
    task automatic settle();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        cfg_t   s;
        longint len;
        int     phase_end;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // next with no transfer, a one-chunk transfer, next after it ends
        send_item(make_item(OP_NEXT));
        send_item('{OP_START, 16'hffff, 32'hffff_ffff, 32'hffff_ffff});
        send_item(make_item(OP_NEXT));
        settle();

        // levels above the maximum, zero length, zero inner count, address wrap
        s = '{2'd3, 16'd0, 16'd0, 16'd2, 32'h7fff_ffff, 32'h8000_0000,
              32'hffff_ffff, 32'h0000_0001};
        apply_setting(s);
        send_item('{OP_START, 16'h0000, 32'hffff_fff0, 32'h0000_0000});
        send_item(make_item(OP_NEXT));
        send_item(make_item(OP_NEXT));
        settle();

        // one level, outer count unused, start while a transfer runs
        s = '{2'd1, 16'hffff, 16'd3, 16'd5, 32'h0000_0001, 32'h0000_0040,
              32'h8000_0000, 32'hffff_fffc};
        apply_setting(s);
        send_item(make_item(OP_START));
        send_item(make_item(OP_NEXT));
        send_item(make_item(OP_START));
        send_item(make_item(OP_NEXT));
        send_item(make_item(OP_NEXT));
        send_item(make_item(OP_NEXT));
        settle();

        // two levels, full walk with row rewind
        s = '{2'd2, 16'd16, 16'd2, 16'd2, 32'h0000_0100, 32'h0000_1000,
              32'hffff_fffc, 32'h8000_0000};
        apply_setting(s);
        send_item(make_item(OP_START));
        repeat (3) send_item(make_item(OP_NEXT));
        settle();

        // inner count shrunk below the index in the middle of a transfer
        write_reg(REG_COUNT_INNER, 32'd4);
        send_item(make_item(OP_START));
        send_item(make_item(OP_NEXT));
        settle();
        write_reg(REG_COUNT_INNER, 32'd1);
        send_item(make_item(OP_NEXT));
        send_item(make_item(OP_NEXT));
        send_item(make_item(OP_NEXT));
        settle();

        while (items_sent < 1520)
        begin
            settle();
            apply_setting(random_setting());
            phase_end = items_sent + $urandom_range(60, 140);
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(make_item(OP_NEXT));
                else
                begin
                    len = chunks_of(setting);
                    // long walks and some short ones are cut by the next start
                    if (len > 48)
                        len = $urandom_range(1, 48);
                    else if ($urandom_range(0, 7) == 0)
                        len = $urandom_range(1, int'(len));
                    send_item(make_item(OP_START));
                    repeat (len - 1) send_item(make_item(OP_NEXT));
                end
            end
        end

        settle();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (failures == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* strided_get_address_walker.f */
sv/sgaw_pkg.sv
sv/sgaw_regs.sv
sv/strided_get_address_walker.sv
sv/sgaw_checker.sv
tb/sv/get_command_checker.sv
tb/sv/testbench.sv
